>>> rtl/assert_macros.svh
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dss assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dss assertion failed");

`endif

>>> rtl/dss_pkg.sv
// Package for the distinct sorted set: payload structs, cell link and command structs, defaults.
// No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

    localparam int DSS_CAPACITY    = 32;
    localparam int DSS_VALUE_WIDTH = 32;
    localparam int DSS_PORT_WIDTH  = 32;

    typedef struct packed {
        logic signed [DSS_PORT_WIDTH-1:0] value;
        logic                             last;
    } t_dss_in;

    typedef struct packed {
        logic signed [DSS_PORT_WIDTH-1:0] value_res;
        logic                             last_res;
        logic                             overflow;
    } t_dss_out;

    // Status one cell hands to its right neighbor.
    typedef struct packed {
        logic vld;
        logic gt;
    } t_dss_link;

    // Commands broadcast to every cell.
    typedef struct packed {
        logic ins;
        logic pop;
    } t_dss_ctl;

endpackage

>>> rtl/dss_cell.sv
// One storage cell of the sorted chain: holds a value, compares it with the new one.
// Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_cell
    import dss_pkg::*;
#(
    parameter int VALUE_WIDTH = DSS_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dss_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_new,
    input  logic [VALUE_WIDTH-1:0] i_left_val,
    input  t_dss_link              i_left,
    input  logic [VALUE_WIDTH-1:0] i_right_val,
    input  logic                   i_right_vld,
    output logic [VALUE_WIDTH-1:0] o_val,
    output t_dss_link              o_link,
    output logic                   o_eq
);

    logic [VALUE_WIDTH-1:0] r_val;
    logic [VALUE_WIDTH-1:0] n_val;
    logic                   r_vld;
    logic                   n_vld;
    logic                   w_gt;

    assign w_gt = r_vld && ($signed(r_val) > $signed(i_new));
    assign o_eq = r_vld && (r_val == i_new);
    assign o_val = r_val;
    assign o_link = '{vld: r_vld, gt: w_gt};

    always_comb begin
        n_val = r_val;
        n_vld = r_vld;
        if (i_ctl.pop) begin
            // advance toward the output end
            n_val = i_right_val;
            n_vld = i_right_vld;
        end else if (i_ctl.ins) begin
            if (i_left.gt) begin
                // make room: take the left neighbor's value
                n_val = i_left_val;
                n_vld = 1'b1;
            end else if (i_left.vld && (w_gt || !r_vld)) begin
                n_val = i_new;
                n_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

endmodule

>>> rtl/distinct_sorted_set.sv
// Top level of the distinct sorted set: chain of cells, drain control, output register.
// Depends on dss_pkg and dss_cell.
//
//   channel  dir  handshake                  payload
//   in       in   i_in_valid / o_in_ready    i_in_data  (t_dss_in)
//   out      out  o_out_valid / i_out_ready  o_out_data (t_dss_out)
//
// A value is taken while input is open: every cell compares against it at once and
// the chain shifts right by one from the insertion point.
// After a last value the chain drains one result per cycle from cell 0 unless the
// output register stalls, which holds the chain; input is held off meanwhile.
// Reset is synchronous, active low, and clears the valid bits and flags.
`timescale 1ns / 1ps

module distinct_sorted_set
    import dss_pkg::*;
#(
    parameter int CAPACITY    = DSS_CAPACITY,
    parameter int VALUE_WIDTH = DSS_VALUE_WIDTH
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dss_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_dss_out o_out_data
);

    logic [VALUE_WIDTH-1:0] w_new;
    logic [VALUE_WIDTH-1:0] w_val  [CAPACITY];
    t_dss_link              w_link [CAPACITY];
    logic [CAPACITY-1:0]    w_eq;
    t_dss_ctl               w_ctl;
    logic                   w_in_acc;
    logic                   w_dup;
    logic                   w_full;
    logic                   w_final;
    logic [DSS_PORT_WIDTH-1:0] w_res;

    logic     r_drain;
    logic     r_drop;
    logic     r_out_vld;
    t_dss_out r_out;

    // Port width to storage width and back, two's complement.
    generate
        if (VALUE_WIDTH <= DSS_PORT_WIDTH) begin : g_narrow
            assign w_new = i_in_data.value[VALUE_WIDTH-1:0];
            assign w_res = {{(DSS_PORT_WIDTH-VALUE_WIDTH+1){w_val[0][VALUE_WIDTH-1]}},
                            w_val[0][VALUE_WIDTH-2:0]};
        end else begin : g_wide
            assign w_new = {{(VALUE_WIDTH-DSS_PORT_WIDTH){i_in_data.value[DSS_PORT_WIDTH-1]}},
                            i_in_data.value};
            assign w_res = w_val[0][DSS_PORT_WIDTH-1:0];
        end
    endgenerate

    assign o_in_ready = !r_drain;
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_dup      = |w_eq;
    assign w_full     = w_link[CAPACITY-1].vld;
    assign w_ctl.ins  = w_in_acc && !w_dup && !w_full;
    assign w_ctl.pop  = r_drain && (!r_out_vld || i_out_ready);
    assign w_final    = !w_link[1].vld;

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            logic [VALUE_WIDTH-1:0] w_lval;
            t_dss_link              w_lnk;
            logic [VALUE_WIDTH-1:0] w_rval;
            logic                   w_rvld;

            if (i == 0) begin : g_head
                assign w_lval = '0;
                assign w_lnk  = '{vld: 1'b1, gt: 1'b0};
            end else begin : g_body
                assign w_lval = w_val[i-1];
                assign w_lnk  = w_link[i-1];
            end

            if (i == CAPACITY - 1) begin : g_tail
                assign w_rval = '0;
                assign w_rvld = 1'b0;
            end else begin : g_mid
                assign w_rval = w_val[i+1];
                assign w_rvld = w_link[i+1].vld;
            end

            dss_cell #(
                .VALUE_WIDTH(VALUE_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (w_ctl),
                .i_new       (w_new),
                .i_left_val  (w_lval),
                .i_left      (w_lnk),
                .i_right_val (w_rval),
                .i_right_vld (w_rvld),
                .o_val       (w_val[i]),
                .o_link      (w_link[i]),
                .o_eq        (w_eq[i])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain   <= 1'b0;
            r_drop    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_in_acc && !w_dup && w_full) begin
                r_drop <= 1'b1;
            end
            if (w_in_acc && i_in_data.last) begin
                r_drain <= 1'b1;
            end
            if (w_ctl.pop) begin
                r_out_vld <= 1'b1;
                if (w_final) begin
                    // end of set: reopen input, clear the drop flag
                    r_drain <= 1'b0;
                    r_drop  <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.pop) begin
            r_out.value_res <= w_res;
            r_out.last_res  <= w_final;
            r_out.overflow  <= r_drop;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> rtl/dss_checker.sv
// Port-level checker for distinct_sorted_set, attached by bind.
// Depends on dss_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dss_checker
    import dss_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     o_in_ready,
    input t_dss_in  i_in_data,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_dss_out o_out_data
);

    `DSS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `DSS_ASSERT_NEXT(a_last_blocks, i_clk, i_rst_n, i_in_valid && o_in_ready && i_in_data.last, !o_in_ready)
    `DSS_ASSERT_NEXT(a_load_open, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_in_data.last, o_in_ready)
    `DSS_ASSERT_NEXT(a_drain_cont, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_out_data.last_res, o_out_valid)
    `DSS_ASSERT_SAME(a_mid_set, i_clk, i_rst_n, o_out_valid && !o_out_data.last_res, !o_in_ready)

endmodule

bind distinct_sorted_set dss_checker u_dss_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> tb/sv/tb_distinct_sorted_set.sv
// Testbench for distinct_sorted_set: directed table, then random sets, checked in order
// against table rows or a model of the sorted distinct store. Depends on dss_pkg and RTL.
`timescale 1ns / 1ps

module tb_distinct_sorted_set;
    import dss_pkg::*;

    localparam int CYCLE_LIMIT   = 100000;
    localparam int RANDOM_ITEMS  = 300;
    localparam int DRAIN_CYCLES  = DSS_CAPACITY + 20;
    localparam int REPORT_LIMIT  = 10;
    localparam logic signed [DSS_PORT_WIDTH-1:0] VAL_MIN = {1'b1, {(DSS_PORT_WIDTH-1){1'b0}}};
    localparam logic signed [DSS_PORT_WIDTH-1:0] VAL_MAX = {1'b0, {(DSS_PORT_WIDTH-1){1'b1}}};

    typedef struct {
        t_dss_in  item;
        bit       typed;
        t_dss_out want;
    } t_dir_row;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    t_dss_in  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    t_dss_out out_data;

    // model of the store
    logic signed [DSS_VALUE_WIDTH-1:0] sorted_vals[$];
    bit                                lost_distinct = 1'b0;

    t_dss_out  pending_results[$];
    t_dir_row  dir_rows[$];
    bit        calm = 1'b0;
    int        cycle_count = 0;
    int        n_items = 0;
    int        n_sets = 0;
    int        n_results = 0;
    int        n_overflow_sets = 0;
    int        n_random = 0;
    int        errors = 0;

    distinct_sorted_set dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("tb_distinct_sorted_set: FAIL");
            $finish;
        end
    end

    // Insert one value into the sorted store; on the last flag, queue the set if keep.
    function automatic void predict_item(t_dss_in it, bit keep);
        logic signed [DSS_VALUE_WIDTH-1:0] v;
        t_dss_out r;
        int pos;
        v = it.value[DSS_VALUE_WIDTH-1:0];
        pos = 0;
        while (pos < sorted_vals.size() && sorted_vals[pos] < v)
            pos++;
        if (pos < sorted_vals.size() && sorted_vals[pos] == v) begin
            // duplicate: drop, no state change
        end else if (sorted_vals.size() >= DSS_CAPACITY) begin
            lost_distinct = 1'b1;
        end else begin
            sorted_vals.insert(pos, v);
        end
        if (it.last) begin
            n_sets++;
            if (lost_distinct)
                n_overflow_sets++;
            for (int k = 0; k < sorted_vals.size(); k++) begin
                r.value_res = sorted_vals[k];
                r.last_res  = (k == sorted_vals.size() - 1);
                r.overflow  = lost_distinct;
                if (keep)
                    pending_results.push_back(r);
            end
            sorted_vals.delete();
            lost_distinct = 1'b0;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_item(t_dss_in it, bit typed, t_dss_out want);
        while (!calm && $urandom_range(0, 99) < 28) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do
            @(posedge clk);
        while (!in_ready);
        n_items++;
        predict_item(it, !typed);
        if (typed)
            pending_results.push_back(want);
        @(negedge clk);
    endtask

    function automatic void add_row(logic signed [DSS_PORT_WIDTH-1:0] v, bit l, bit typed,
                                    logic signed [DSS_PORT_WIDTH-1:0] wv, bit wl, bit wo);
        t_dir_row row;
        row.item.value     = v;
        row.item.last      = l;
        row.typed          = typed;
        row.want.value_res = wv;
        row.want.last_res  = wl;
        row.want.overflow  = wo;
        dir_rows.push_back(row);
    endfunction

    always @(negedge clk)
        out_ready <= calm || ($urandom_range(0, 99) >= 28);

    always @(posedge clk) begin
        t_dss_out exp_r;
        if (rst_n && out_valid && out_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("unexpected result: value %0d last %0b overflow %0b",
                             out_data.value_res, out_data.last_res, out_data.overflow);
            end else begin
                exp_r = pending_results.pop_front();
                if (out_data.value_res !== exp_r.value_res ||
                    out_data.last_res !== exp_r.last_res ||
                    out_data.overflow !== exp_r.overflow) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                                 exp_r.value_res, exp_r.last_res, exp_r.overflow,
                                 out_data.value_res, out_data.last_res, out_data.overflow);
                end
            end
        end
    end

    task automatic run_random();
        t_dss_in  it;
        t_dss_out none;
        int mode;
        int set_len;
        int pick;
        logic [DSS_PORT_WIDTH-1:0] word;
        logic signed [DSS_PORT_WIDTH-1:0] seen[$];
        none = '0;
        while (n_random < RANDOM_ITEMS) begin
            mode = $urandom_range(0, 9);
            if (mode < 5)
                set_len = $urandom_range(1, 8);
            else if (mode < 8)
                set_len = $urandom_range(9, 24);
            else
                set_len = $urandom_range(31, 40);
            seen.delete();
            for (int k = 0; k < set_len; k++) begin
                word = $urandom;
                if (mode >= 8) begin
                    // index in the low bits keeps values distinct; repeat one now and then
                    if (seen.size() > 0 && $urandom_range(0, 5) == 0)
                        it.value = seen[$urandom_range(0, seen.size() - 1)];
                    else
                        it.value = {word[DSS_PORT_WIDTH-1:6], 6'(k)};
                end else begin
                    pick = $urandom_range(0, 2);
                    if (pick == 0)
                        it.value = $signed($urandom_range(0, 8)) - 4;
                    else if (pick == 1)
                        it.value = word;
                    else
                        case ($urandom_range(0, 3))
                            0: it.value = VAL_MIN;
                            1: it.value = VAL_MAX;
                            2: it.value = '0;
                            default: it.value = '1;
                        endcase
                end
                it.last = (k == set_len - 1);
                seen.push_back(it.value);
                calm = (n_random >= 120 && n_random < 200);
                send_item(it, 1'b0, none);
                n_random++;
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        int drain;
        // single-value sets: readable at a glance
        add_row(VAL_MIN, 1'b1, 1'b1, VAL_MIN, 1'b1, 1'b0);
        add_row(VAL_MAX, 1'b1, 1'b1, VAL_MAX, 1'b1, 1'b0);
        add_row(0, 1'b1, 1'b1, 0, 1'b1, 1'b0);
        add_row(-1, 1'b1, 1'b1, -1, 1'b1, 1'b0);
        // duplicate as the final value still closes the set
        add_row(5, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(5, 1'b1, 1'b1, 5, 1'b1, 1'b0);
        // mixed signs, extremes and duplicates
        add_row(7, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(-3, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(7, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(VAL_MAX, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(VAL_MIN, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(-3, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        add_row(1, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(-1, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(0, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(1, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(-1, 1'b1, 1'b0, 0, 1'b0, 1'b0);
        add_row(32'h5555_5555, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(32'hAAAA_AAAA, 1'b0, 1'b0, 0, 1'b0, 1'b0);
        add_row(32'h0000_0001, 1'b1, 1'b0, 0, 1'b0, 1'b0);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
        run_random();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        for (drain = 0; drain < DRAIN_CYCLES; drain++)
            @(posedge clk);

        $display("%0d items in %0d sets, %0d results checked, %0d sets overflowed the store",
                 n_items, n_sets, n_results, n_overflow_sets);
        $display("%0d failures", errors);
        if (errors == 0) begin
            $display("tb_distinct_sorted_set: PASS");
        end else begin
            $display("tb_distinct_sorted_set: FAIL");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl
rtl/dss_pkg.sv
rtl/dss_cell.sv
rtl/distinct_sorted_set.sv
rtl/dss_checker.sv
tb/sv/tb_distinct_sorted_set.sv
